// ===== hw/rtl/mgsa_pkg.sv =====
// Shared types and constants of the max-gap slot allocator.
// Used by mgsa_word_scan and max_gap_slot_allocator; depends on nothing.
package mgsa_pkg;

	// Bitmap word held in one memory entry
	localparam int WORD_W = 16;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int LIM_W  = $clog2(WORD_W + 1);

	// Fixed field widths
	localparam int SLOT_W  = 10;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	// Summary of one bitmap word, restricted to the slots of the row
	typedef struct packed {
		logic             any_occ;
		logic             any_free;
		logic [BIT_W-1:0] first_occ;
		logic [BIT_W-1:0] last_occ;
		logic             int_vld;
		logic [BIT_W-1:0] int_d;
		logic [BIT_W-1:0] int_pos;
	} word_sum_t;

endpackage

// ===== hw/rtl/mgsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
module mgsa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read; a read of the entry being written returns old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/mgsa_word_scan.sv =====
// Per-word gap summary stage: finds occupied edges and the widest interior gap of one
// bitmap word. Depends on mgsa_pkg (word width, word_sum_t).
module mgsa_word_scan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             word_valid,
	input  logic [mgsa_pkg::WORD_W-1:0]      word_data,
	input  logic [mgsa_pkg::LIM_W-1:0]       word_lim,
	output logic                             sum_valid,
	output mgsa_pkg::word_sum_t              sum
);

	import mgsa_pkg::*;

	logic [WORD_W-1:0] mask;
	logic [WORD_W-1:0] occ;
	logic [BIT_W-1:0]  prev_occ [WORD_W];
	logic              has_prev [WORD_W];
	logic [BIT_W-1:0]  gap_d    [WORD_W];
	logic              node_v   [WORD_W];
	logic [BIT_W-1:0]  node_d   [WORD_W];
	logic [BIT_W-1:0]  node_p   [WORD_W];
	logic [BIT_W-1:0]  first_c;
	logic [BIT_W-1:0]  last_c;
	word_sum_t         sum_c;

	always_comb begin
		// Keep only slots that lie inside the row
		for (int j = 0; j < WORD_W; j++) begin
			mask[j] = (LIM_W'(j) < word_lim);
		end
		occ = word_data & mask;

		// Nearest occupied slot below each position
		for (int j = 0; j < WORD_W; j++) begin
			prev_occ[j] = '0;
			has_prev[j] = 1'b0;
			for (int k = 0; k < WORD_W; k++) begin
				if (k < j && occ[k]) begin
					prev_occ[j] = BIT_W'(k);
					has_prev[j] = 1'b1;
				end
			end
		end

		// One candidate per occupied slot that closes a gap inside the word
		for (int j = 0; j < WORD_W; j++) begin
			gap_d[j]  = (BIT_W'(j) - prev_occ[j]) >> 1;
			node_v[j] = occ[j] & has_prev[j];
			node_d[j] = gap_d[j];
			node_p[j] = prev_occ[j] + gap_d[j];
		end

		// Reduce to the widest gap, lowest position on ties
		for (int lv = 0; lv < BIT_W; lv++) begin
			for (int k = 0; k < (WORD_W >> (lv + 1)); k++) begin
				if (node_v[2*k+1] && (!node_v[2*k] || node_d[2*k+1] > node_d[2*k])) begin
					node_v[k] = node_v[2*k+1];
					node_d[k] = node_d[2*k+1];
					node_p[k] = node_p[2*k+1];
				end else begin
					node_v[k] = node_v[2*k];
					node_d[k] = node_d[2*k];
					node_p[k] = node_p[2*k];
				end
			end
		end

		// Lowest and highest occupied slot
		first_c = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (occ[j]) begin
				first_c = BIT_W'(j);
			end
		end
		last_c = '0;
		for (int j = 0; j < WORD_W; j++) begin
			if (occ[j]) begin
				last_c = BIT_W'(j);
			end
		end

		sum_c.any_occ   = |occ;
		sum_c.any_free  = |(~word_data & mask);
		sum_c.first_occ = first_c;
		sum_c.last_occ  = last_c;
		sum_c.int_vld   = node_v[0];
		sum_c.int_d     = node_d[0];
		sum_c.int_pos   = node_p[0];
	end

	// Register the summary
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid <= 1'b0;
		end else begin
			sum_valid <= word_valid;
		end
	end

	always_ff @(posedge clk) begin
		sum <= sum_c;
	end

endmodule

// ===== hw/rtl/max_gap_slot_allocator.sv =====
// Top level of the max-gap slot allocator: control, accumulation and bitmap memory.
// Depends on mgsa_pkg, mgsa_ram and mgsa_word_scan.
//
// The occupancy bitmap of the row lives in one RAM of WORD_W-bit words. An allocate
// streams the words that cover the first seat_count slots through a two-stage scan,
// one word per cycle, then writes the chosen slot back with a read-modify-write. A full
// row skips the write-back, and a row of zero slots reports full. A release does one
// read and one write. One item is worked on at a time; a finished result waits in the
// output register while the next item is accepted. After reset a clearing pass
// zeroes the bitmap, during which no item is accepted; configuration writes are always
// accepted.
module max_gap_slot_allocator #(
	parameter int MAX_SLOTS = 1024
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [mgsa_pkg::COUNT_W-1:0] cfg_data,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         action,
	input  logic [mgsa_pkg::SLOT_W-1:0]  release_slot,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mgsa_pkg::SLOT_W-1:0]  chosen_slot,
	output logic                         row_full
);

	import mgsa_pkg::*;

	localparam int WORDS  = (MAX_SLOTS + WORD_W - 1) / WORD_W;
	localparam int WA     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW     = $clog2(MAX_SLOTS + 1);
	localparam int BASE_W = WA + BIT_W;
	localparam int CW     = (PW > BASE_W) ? PW + 1 : BASE_W + 1;
	localparam logic [WA-1:0] LAST_WORD = WA'(WORDS - 1);

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_REL_RD  = 4'd2;
	localparam logic [3:0] ST_REL_WR  = 4'd3;
	localparam logic [3:0] ST_SCAN    = 4'd4;
	localparam logic [3:0] ST_FINAL   = 4'd5;
	localparam logic [3:0] ST_MARK_RD = 4'd6;
	localparam logic [3:0] ST_MARK_WR = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	localparam logic ACT_RELEASE = 1'b1;

	logic [3:0]         state_q;
	logic [COUNT_W-1:0] seat_count_q;
	logic [PW-1:0]      n_c;
	logic [PW-1:0]      n_q;
	logic [WA-1:0]      clr_addr_q;
	logic [WA-1:0]      rd_addr_q;
	logic               issuing_q;
	logic               rd_v_s1;
	logic [WA-1:0]      idx_s1;
	logic [LIM_W-1:0]   lim_s1;
	logic [CW-1:0]      rem_c;
	logic [CW-1:0]      next_base_c;
	logic               issue_stop_c;
	logic               sum_v_s2;
	word_sum_t          sum_s2;
	logic [WA-1:0]      idx_s2;
	logic [PW-1:0]      base_s2;
	logic               seen_q;
	logic [PW-1:0]      start_q;
	logic [PW-1:0]      best_q;
	logic [PW-1:0]      pick_q;
	logic               free_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               out_valid_q;
	logic [SLOT_W-1:0]  chosen_q;
	logic               full_q;
	logic               in_acc;
	logic               out_load;
	logic               slot_in_range;
	logic [PW-1:0]      edge_pos_c;
	logic [PW-1:0]      cand_d_c;
	logic [PW-1:0]      cand_p_c;
	logic [PW-1:0]      best1_c;
	logic [PW-1:0]      pick1_c;
	logic [PW-1:0]      best2_c;
	logic [PW-1:0]      pick2_c;
	logic [PW-1:0]      tail_c;
	logic [WA-1:0]      rel_word;
	logic [WA-1:0]      pick_word;
	logic [WORD_W-1:0]  rel_bit;
	logic [WORD_W-1:0]  pick_bit;
	logic               ram_we;
	logic [WA-1:0]      ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WA-1:0]      ram_raddr;
	logic [WORD_W-1:0]  ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid   = out_valid_q;
	assign chosen_slot = chosen_q;
	assign row_full    = full_q;

	// Effective row length: seat count clamped to capacity
	always_comb begin
		if (32'(seat_count_q) > 32'(MAX_SLOTS)) begin
			n_c = PW'(MAX_SLOTS);
		end else begin
			n_c = PW'(seat_count_q);
		end
	end

	assign slot_in_range = (32'(release_slot) < 32'(MAX_SLOTS));

	// Word and bit of the release slot and of the chosen slot
	assign rel_word  = WA'(slot_q >> BIT_W);
	assign rel_bit   = WORD_W'(1) << slot_q[BIT_W-1:0];
	assign pick_word = WA'(pick_q >> BIT_W);
	assign pick_bit  = WORD_W'(1) << BIT_W'(pick_q);

	// Stop issuing after the last word that holds slots of the row
	assign next_base_c  = CW'({rd_addr_q, {BIT_W{1'b0}}}) + CW'(WORD_W);
	assign issue_stop_c = (rd_addr_q == LAST_WORD) || (next_base_c >= CW'(n_q));

	// Number of row slots in the word now leaving the memory
	assign rem_c = CW'(n_q) - CW'({idx_s1, {BIT_W{1'b0}}});
	assign lim_s1 = (rem_c >= CW'(WORD_W)) ? LIM_W'(WORD_W) : LIM_W'(rem_c);

	// Memory port selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_addr_q;
		ram_wdata = '0;
		ram_raddr = rd_addr_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_REL_RD: begin
				ram_raddr = rel_word;
			end
			ST_REL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = rel_word;
				ram_wdata = ram_rdata & ~rel_bit;
			end
			ST_MARK_RD: begin
				ram_raddr = pick_word;
			end
			ST_MARK_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pick_word;
				ram_wdata = ram_rdata | pick_bit;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	mgsa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(WORDS)
	) u_map_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	mgsa_word_scan u_word_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.word_valid(rd_v_s1),
		.word_data (ram_rdata),
		.word_lim  (lim_s1),
		.sum_valid (sum_v_s2),
		.sum       (sum_s2)
	);

	// Fold one word summary into the running best gap, in slot order
	always_comb begin
		base_s2    = PW'({idx_s2, {BIT_W{1'b0}}});
		edge_pos_c = base_s2 + PW'(sum_s2.first_occ);
		if (seen_q) begin
			cand_d_c = (edge_pos_c - start_q + PW'(1)) >> 1;
			cand_p_c = start_q + cand_d_c - PW'(1);
		end else begin
			cand_d_c = edge_pos_c;
			cand_p_c = '0;
		end
		if (best_q < cand_d_c) begin
			best1_c = cand_d_c;
			pick1_c = cand_p_c;
		end else begin
			best1_c = best_q;
			pick1_c = pick_q;
		end
		if (sum_s2.int_vld && best1_c < PW'(sum_s2.int_d)) begin
			best2_c = PW'(sum_s2.int_d);
			pick2_c = base_s2 + PW'(sum_s2.int_pos);
		end else begin
			best2_c = best1_c;
			pick2_c = pick1_c;
		end
		tail_c = n_q - start_q;
	end

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			seat_count_q <= COUNT_RESET;
			clr_addr_q   <= '0;
			issuing_q    <= 1'b0;
			rd_v_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seat_count_q <= cfg_data;
			end
			rd_v_s1 <= (state_q == ST_SCAN) && issuing_q;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + WA'(1);
					if (clr_addr_q == LAST_WORD) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						if (action == ACT_RELEASE) begin
							if (slot_in_range) begin
								state_q <= ST_REL_RD;
							end
						end else begin
							state_q   <= ST_SCAN;
							issuing_q <= (n_c != '0);
						end
					end
				end
				ST_REL_RD: begin
					state_q <= ST_REL_WR;
				end
				ST_REL_WR: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (issuing_q && issue_stop_c) begin
						issuing_q <= 1'b0;
					end
					if (!issuing_q && !rd_v_s1 && !sum_v_s2) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					state_q <= free_q ? ST_MARK_RD : ST_DONE;
				end
				ST_MARK_RD: begin
					state_q <= ST_MARK_WR;
				end
				ST_MARK_WR: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: scan address, word index pipeline, accumulators, result
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
		idx_s2 <= idx_s1;
		if (in_acc) begin
			slot_q    <= release_slot;
			n_q       <= n_c;
			rd_addr_q <= '0;
			seen_q    <= 1'b0;
			start_q   <= '0;
			best_q    <= '0;
			pick_q    <= '0;
			free_q    <= 1'b0;
		end else begin
			if (state_q == ST_SCAN && issuing_q) begin
				rd_addr_q <= rd_addr_q + WA'(1);
			end
			if (sum_v_s2) begin
				free_q <= free_q | sum_s2.any_free;
				if (sum_s2.any_occ) begin
					seen_q  <= 1'b1;
					best_q  <= best2_c;
					pick_q  <= pick2_c;
					start_q <= base_s2 + PW'(sum_s2.last_occ) + PW'(1);
				end
			end
			// Right-hand edge of the row
			if (state_q == ST_FINAL && seen_q && best_q < tail_c) begin
				pick_q <= n_q - PW'(1);
			end
		end
		if (out_load) begin
			chosen_q <= free_q ? SLOT_W'(pick_q) : '0;
			full_q   <= !free_q;
		end
	end

	// Scan pipeline only runs during a scan
	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_v_s1 || sum_v_s2) |-> (state_q == ST_SCAN))
		else $error("scan pipeline active outside a scan");

	// A full row reports slot zero
	a_full_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && row_full) |-> (chosen_slot == '0))
		else $error("full row result with nonzero slot");

	// The chosen slot lies inside the row when it is marked
	a_pick_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MARK_RD) |-> (pick_q < n_q))
		else $error("chosen slot beyond row length");

	// Run start and best gap never pass the row end
	a_start_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |-> (start_q <= n_q && best_q <= n_q))
		else $error("gap accumulator out of range");

	// No item is taken while the bitmap is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !$past(in_acc))
		else $error("item accepted during clearing pass");

endmodule
